// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/gbts_pkg.sv =====
// types, constants and field layouts of the bilinear texture sampler
package gbts_pkg;

  localparam int unsigned MAP_WIDTH_MAX  = 1024;
  localparam int unsigned MAP_HEIGHT_MAX = 512;

  // texel index widths and per-bank index widths (four banks by x and y parity)
  localparam int unsigned X_W        = $clog2(MAP_WIDTH_MAX);
  localparam int unsigned Y_W        = $clog2(MAP_HEIGHT_MAX);
  localparam int unsigned COL_W      = (X_W > 1) ? X_W - 1 : 1;
  localparam int unsigned ROW_W      = (Y_W > 1) ? Y_W - 1 : 1;
  localparam int unsigned BANK_AW    = COL_W + ROW_W;
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;
  localparam int unsigned NUM_BANKS  = 4;

  // item field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TEX_X_W   = 10;
  localparam int unsigned TEX_Y_W   = 9;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned RGB_W     = 3 * COLOR_W;
  localparam int unsigned COORD_W   = 17;
  localparam int unsigned LAT_W     = 25;
  localparam int unsigned LON_W     = 26;
  localparam int unsigned CHAN_W    = 16;
  localparam int unsigned OUT_W     = 3 * CHAN_W;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_WID_W = 11;
  localparam int unsigned CFG_HGT_W = 10;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAP_LOADED = 2'd2;
  localparam logic [CFG_WID_W-1:0] MAP_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_HGT_W-1:0] MAP_HEIGHT_RST = 10'd512;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE_UV  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE_GEO = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

  // fixed point constants
  localparam int unsigned ONE_Q16 = 65536;
  localparam logic [CHAN_W-1:0] FULL_SCALE = 16'd65280;
  localparam logic [CHAN_W-1:0] GRAY_LEVEL = 16'd45696;
  localparam int unsigned DEG_55  = 55 * 65536;
  localparam int unsigned DEG_180 = 180 * 65536;
  localparam int unsigned DEG_360 = 360 * 65536;

  // x / 360 = (x >> 3) / 45 and x / 110 = (x >> 1) / 55, by reciprocal multiply
  localparam int unsigned U_N_W       = 22;
  localparam int unsigned V_N_W       = 22;
  localparam int unsigned DIV45_W     = 24;
  localparam int unsigned DIV45_SHIFT = 29;
  localparam logic [DIV45_W-1:0] DIV45_MUL = 24'd11930465;
  localparam int unsigned DIV55_W     = 23;
  localparam int unsigned DIV55_SHIFT = 28;
  localparam logic [DIV55_W-1:0] DIV55_MUL = 23'd4880645;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_SAMPLED     = 2'd0,
    ST_OUT_OF_BAND = 2'd1,
    ST_NOT_LOADED  = 2'd2,
    ST_WRITE_DONE  = 2'd3
  } status_e;

  // input tdata layout, tex_x in the lowest bits
  typedef struct packed {
    logic signed [LON_W-1:0] longitude;
    logic signed [LAT_W-1:0] latitude;
    logic [COORD_W-1:0]      coord_v;
    logic [COORD_W-1:0]      coord_u;
    logic [COLOR_W-1:0]      blue;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      red;
    logic [TEX_Y_W-1:0]      tex_y;
    logic [TEX_X_W-1:0]      tex_x;
  } in_data_t;

  localparam int unsigned IN_DATA_W = $bits(in_data_t);

  typedef struct packed {
    logic           ready;
    logic [X_W-1:0] w_m1;
    logic [Y_W-1:0] h_m1;
  } cfg_t;

  // classified item, as queued between front and back
  typedef struct packed {
    status_e            status;
    logic               wr_en;
    logic [X_W-1:0]     wx;
    logic [Y_W-1:0]     wy;
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } item_t;

endpackage

// ===== hw/rtl/gbts_front.sv =====
// front end: input register, opcode classification and geographic mapping
module gbts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbts_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [gbts_pkg::OP_W-1:0] in_op_i,
  input  gbts_pkg::in_data_t in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output gbts_pkg::item_t   item_o
);
  import gbts_pkg::*;

  localparam int unsigned SW = LON_W + 1;
  localparam int unsigned DW = LAT_W + 1;

  logic              f_adv;
  logic              s0_valid_q;
  logic [OP_W-1:0]   s0_op_q;
  in_data_t          s0_data_q;

  logic               s1_valid_q;
  status_e            s1_status_q, s1_status_d;
  logic               s1_geo_q;
  logic               s1_wr_en_q, s1_wr_en_d;
  logic [X_W-1:0]     s1_wx_q;
  logic [Y_W-1:0]     s1_wy_q;
  logic [RGB_W-1:0]   s1_rgb_q;
  logic [COORD_W-1:0] s1_u_q, s1_v_q;
  logic [U_N_W-1:0]   s1_nu_q, s1_nu_d;
  logic [V_N_W-1:0]   s1_nv_q, s1_nv_d;

  logic signed [SW-1:0] s_raw, s_wrap;
  logic signed [DW-1:0] lat_x, v_span;
  logic                 in_band;
  logic [31:0]          wx_ext, wy_ext;

  logic [U_N_W+DIV45_W-1:0] prod_u;
  logic [V_N_W+DIV55_W-1:0] prod_v;

  assign f_adv      = !s1_valid_q || !full_i;
  assign in_ready_o = f_adv;
  assign push_o     = s1_valid_q && !full_i;

  // longitude shifted to 0..360 degrees, wrapped once
  assign s_raw = $signed({s0_data_q.longitude[LON_W-1], s0_data_q.longitude})
               + $signed(SW'(DEG_180));
  always_comb begin
    if (s_raw >= $signed(SW'(DEG_360))) begin
      s_wrap = s_raw - $signed(SW'(DEG_360));
    end else if (s_raw < 0) begin
      s_wrap = s_raw + $signed(SW'(DEG_360));
    end else begin
      s_wrap = s_raw;
    end
  end
  assign s1_nu_d = s_wrap[U_N_W+2:3];

  assign lat_x   = $signed({s0_data_q.latitude[LAT_W-1], s0_data_q.latitude});
  assign in_band = (lat_x <= $signed(DW'(DEG_55))) && (lat_x > -$signed(DW'(DEG_55)));
  assign v_span  = $signed(DW'(DEG_55)) - lat_x;
  assign s1_nv_d = v_span[V_N_W:1];

  assign wx_ext     = 32'(s0_data_q.tex_x);
  assign wy_ext     = 32'(s0_data_q.tex_y);
  assign s1_wr_en_d = (wx_ext < MAP_WIDTH_MAX) && (wy_ext < MAP_HEIGHT_MAX);

  always_comb begin
    case (s0_op_q)
      OP_WRITE: begin
        s1_status_d = ST_WRITE_DONE;
      end
      OP_SAMPLE_UV: begin
        s1_status_d = cfg_i.ready ? ST_SAMPLED : ST_NOT_LOADED;
      end
      OP_SAMPLE_GEO: begin
        if (!cfg_i.ready) begin
          s1_status_d = ST_NOT_LOADED;
        end else if (!in_band) begin
          s1_status_d = ST_OUT_OF_BAND;
        end else begin
          s1_status_d = ST_SAMPLED;
        end
      end
      default: begin
        s1_status_d = ST_WRITE_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (f_adv) begin
      // opcode 3 is taken and dropped here
      s0_valid_q <= in_valid_i && (in_op_i != OP_NONE);
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      s0_op_q      <= in_op_i;
      s0_data_q    <= in_data_i;
      s1_status_q  <= s1_status_d;
      s1_geo_q     <= (s0_op_q == OP_SAMPLE_GEO);
      s1_wr_en_q   <= s1_wr_en_d;
      s1_wx_q      <= X_W'(wx_ext);
      s1_wy_q      <= Y_W'(wy_ext);
      s1_rgb_q     <= {s0_data_q.blue, s0_data_q.green, s0_data_q.red};
      s1_u_q       <= s0_data_q.coord_u;
      s1_v_q       <= s0_data_q.coord_v;
      s1_nu_q      <= s1_nu_d;
      s1_nv_q      <= s1_nv_d;
    end
  end

  assign prod_u = s1_nu_q * DIV45_MUL;
  assign prod_v = s1_nv_q * DIV55_MUL;

  always_comb begin
    item_o.status = s1_status_q;
    item_o.wr_en  = s1_wr_en_q;
    item_o.wx     = s1_wx_q;
    item_o.wy     = s1_wy_q;
    item_o.rgb    = s1_rgb_q;
    item_o.u      = s1_geo_q ? prod_u[DIV45_SHIFT +: COORD_W] : s1_u_q;
    item_o.v      = s1_geo_q ? prod_v[DIV55_SHIFT +: COORD_W] : s1_v_q;
  end

endmodule

// ===== hw/rtl/gbts_fifo.sv =====
// short queue of classified items between front and back
`include "assert_macros.svh"

module gbts_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gbts_pkg::item_t item_i,
  input  logic            pop_i,
  output gbts_pkg::item_t head_o,
  output logic            full_o,
  output logic            empty_o
);
  import gbts_pkg::*;

  item_t              slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")
  `ASSERT_AT_CLK(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

// ===== hw/rtl/gbts_back.sv =====
// back end: texel addressing, banked texture memory, bilinear blend, output register
`include "assert_macros.svh"

module gbts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbts_pkg::cfg_t                cfg_i,
  input  logic                          empty_i,
  input  gbts_pkg::item_t               head_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [gbts_pkg::OUT_W-1:0]    m_data_o,
  output logic [gbts_pkg::STATUS_W-1:0] m_status_o
);
  import gbts_pkg::*;

  localparam int unsigned W_W   = FRAC_W + 1;
  localparam int unsigned TOP_W = COLOR_W + FRAC_W;
  localparam int unsigned SUM_W = TOP_W + W_W;

  logic b_adv;

  // address stage
  logic [COORD_W-1:0]       uc, vc;
  logic [COORD_W+X_W-1:0]   px;
  logic [COORD_W+Y_W-1:0]   py;
  logic                     p_valid_q;
  status_e                  p_status_q;
  logic                     p_wr_en_q;
  logic [X_W-1:0]           p_wx_q, p_x0_q;
  logic [Y_W-1:0]           p_wy_q, p_y0_q;
  logic [RGB_W-1:0]         p_rgb_q;
  logic [FRAC_W-1:0]        p_tx_q, p_ty_q;

  // memory stage
  logic [X_W-1:0]           x1;
  logic [Y_W-1:0]           y1;
  logic [COL_W-1:0]         rd_col [NUM_BANKS];
  logic [ROW_W-1:0]         rd_row [NUM_BANKS];
  logic [BANK_AW-1:0]       wr_addr;
  logic [NUM_BANKS-1:0]     bank_we;
  logic [RGB_W-1:0]         bank_rd_q [NUM_BANKS];
  logic                     m_valid_q;
  status_e                  m_status_q;
  logic                     m_x0p_q, m_x1p_q, m_y0p_q, m_y1p_q;
  logic [FRAC_W-1:0]        m_tx_q, m_ty_q;

  // horizontal blend stage
  logic [RGB_W-1:0]         w00, w10, w01, w11;
  logic [W_W-1:0]           wx0, wx1, wy0, wy1;
  logic [TOP_W-1:0]         top_d [3];
  logic [TOP_W-1:0]         bot_d [3];
  logic [TOP_W-1:0]         h_top_q [3];
  logic [TOP_W-1:0]         h_bot_q [3];
  logic                     h_valid_q;
  status_e                  h_status_q;
  logic [FRAC_W-1:0]        h_ty_q;

  // output stage
  logic [SUM_W-1:0]         sum_d [3];
  logic [CHAN_W-1:0]        chan_d [3];
  logic [CHAN_W-1:0]        out_chan_q [3];
  logic                     out_valid_q;
  status_e                  out_status_q;

  assign b_adv = !out_valid_q || m_ready_i;
  assign pop_o = !empty_i && b_adv;

  // clamp to [0, 1] and scale by size minus one
  assign uc = (head_i.u > COORD_W'(ONE_Q16)) ? COORD_W'(ONE_Q16) : head_i.u;
  assign vc = (head_i.v > COORD_W'(ONE_Q16)) ? COORD_W'(ONE_Q16) : head_i.v;
  assign px = uc * cfg_i.w_m1;
  assign py = vc * cfg_i.h_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      h_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      p_valid_q   <= pop_o;
      m_valid_q   <= p_valid_q;
      h_valid_q   <= m_valid_q;
      out_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      p_status_q <= head_i.status;
      p_wr_en_q  <= head_i.wr_en;
      p_wx_q     <= head_i.wx;
      p_wy_q     <= head_i.wy;
      p_rgb_q    <= head_i.rgb;
      p_x0_q     <= px[FRAC_W +: X_W];
      p_y0_q     <= py[FRAC_W +: Y_W];
      p_tx_q     <= px[FRAC_W-1:0];
      p_ty_q     <= py[FRAC_W-1:0];
    end
  end

  // right and lower neighbours stay on the last column or row
  assign x1 = (p_x0_q == cfg_i.w_m1) ? p_x0_q : p_x0_q + 1'b1;
  assign y1 = (p_y0_q == cfg_i.h_m1) ? p_y0_q : p_y0_q + 1'b1;

  // each bank holds one x parity and one y parity, so every neighbour
  // lands in its own bank, or shares the texel when clamped
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_col[b] = (p_x0_q[0] == 1'(b)) ? COL_W'(p_x0_q >> 1) : COL_W'(x1 >> 1);
      rd_row[b] = (p_y0_q[0] == 1'(b >> 1)) ? ROW_W'(p_y0_q >> 1) : ROW_W'(y1 >> 1);
    end
  end

  assign wr_addr = {ROW_W'(p_wy_q >> 1), COL_W'(p_wx_q >> 1)};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [RGB_W-1:0] tex_mem_q [BANK_DEPTH];

    assign bank_we[b] = b_adv && p_valid_q && (p_status_q == ST_WRITE_DONE) && p_wr_en_q
                     && ({p_wy_q[0], p_wx_q[0]} == 2'(b));

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        tex_mem_q[wr_addr] <= p_rgb_q;
      end
      if (b_adv) begin
        bank_rd_q[b] <= tex_mem_q[{rd_row[b], rd_col[b]}];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      m_status_q <= p_status_q;
      m_x0p_q    <= p_x0_q[0];
      m_x1p_q    <= x1[0];
      m_y0p_q    <= p_y0_q[0];
      m_y1p_q    <= y1[0];
      m_tx_q     <= p_tx_q;
      m_ty_q     <= p_ty_q;
    end
  end

  assign w00 = bank_rd_q[{m_y0p_q, m_x0p_q}];
  assign w10 = bank_rd_q[{m_y0p_q, m_x1p_q}];
  assign w01 = bank_rd_q[{m_y1p_q, m_x0p_q}];
  assign w11 = bank_rd_q[{m_y1p_q, m_x1p_q}];
  assign wx1 = {1'b0, m_tx_q};
  assign wx0 = W_W'(ONE_Q16) - wx1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_d[c] = w00[c*COLOR_W +: COLOR_W] * wx0 + w10[c*COLOR_W +: COLOR_W] * wx1;
      bot_d[c] = w01[c*COLOR_W +: COLOR_W] * wx0 + w11[c*COLOR_W +: COLOR_W] * wx1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      h_status_q <= m_status_q;
      h_ty_q     <= m_ty_q;
      for (int c = 0; c < 3; c++) begin
        h_top_q[c] <= top_d[c];
        h_bot_q[c] <= bot_d[c];
      end
    end
  end

  assign wy1 = {1'b0, h_ty_q};
  assign wy0 = W_W'(ONE_Q16) - wy1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = h_top_q[c] * wy0 + h_bot_q[c] * wy1;
      case (h_status_q)
        ST_SAMPLED:     chan_d[c] = sum_d[c][TOP_W +: CHAN_W];
        ST_OUT_OF_BAND: chan_d[c] = GRAY_LEVEL;
        ST_NOT_LOADED:  chan_d[c] = FULL_SCALE;
        ST_WRITE_DONE:  chan_d[c] = '0;
        default:        chan_d[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_status_q <= h_status_q;
      for (int c = 0; c < 3; c++) begin
        out_chan_q[c] <= chan_d[c];
      end
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_data_o   = {out_chan_q[2], out_chan_q[1], out_chan_q[0]};
  assign m_status_o = out_status_q;

  `ASSERT_AT_CLK(a_write_zero, out_valid_q && out_status_q == ST_WRITE_DONE |-> out_chan_q[0] == '0 && out_chan_q[1] == '0 && out_chan_q[2] == '0, "write result not zero")
  `ASSERT_AT_CLK(a_gray_flat, out_valid_q && out_status_q == ST_OUT_OF_BAND |-> out_chan_q[0] == GRAY_LEVEL && out_chan_q[1] == GRAY_LEVEL && out_chan_q[2] == GRAY_LEVEL, "out of band result not gray")
  `ASSERT_AT_CLK(a_white_flat, out_valid_q && out_status_q == ST_NOT_LOADED |-> out_chan_q[0] == FULL_SCALE && out_chan_q[1] == FULL_SCALE && out_chan_q[2] == FULL_SCALE, "unloaded result not white")

endmodule

// ===== hw/rtl/geo_bilinear_texture_sampler.sv =====
// An item passes the input reg, classify, queue, scale, texture read, horizontal
// blend and vertical blend into output reg. Throughput: one item per cycle unless
// the output is stalled; each of the four parity banks of texture memory serves
// one read per cycle, so the four bilinear neighbours come out together.
// Reset: map_width 1024, map_height 512, map not loaded, pipeline and queue empty;
// texture memory is not cleared and holds garbage until written.
module geo_bilinear_texture_sampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbts_pkg::APB_AW-1:0]     paddr,
  input  logic [gbts_pkg::APB_DW-1:0]     pwdata,
  output logic [gbts_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tex_x, tex_y, red, green, blue, coord_u, coord_v, latitude, longitude
  input  logic [gbts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [gbts_pkg::OP_W-1:0]       s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_red, out_green, out_blue
  output logic [gbts_pkg::OUT_W-1:0]      m_axis_tdata,
  // status
  output logic [gbts_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import gbts_pkg::*;

  logic [CFG_WID_W-1:0] map_width_q;
  logic [CFG_HGT_W-1:0] map_height_q;
  logic                 map_loaded_q;
  logic                 cfg_wr;
  logic [1:0]           reg_sel;
  logic [31:0]          w_eff, h_eff;
  cfg_t                 cfg;

  logic  push, pop, full, empty;
  item_t push_item, head_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      map_loaded_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MAP_WIDTH:  map_width_q  <= pwdata[CFG_WID_W-1:0];
        REG_MAP_HEIGHT: map_height_q <= pwdata[CFG_HGT_W-1:0];
        REG_MAP_LOADED: map_loaded_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAP_WIDTH:  prdata = APB_DW'(map_width_q);
      REG_MAP_HEIGHT: prdata = APB_DW'(map_height_q);
      REG_MAP_LOADED: prdata = APB_DW'(map_loaded_q);
      default:        prdata = '0;
    endcase
  end

  // oversized maps are treated as the maximum
  assign w_eff = (32'(map_width_q) > MAP_WIDTH_MAX) ? MAP_WIDTH_MAX : 32'(map_width_q);
  assign h_eff = (32'(map_height_q) > MAP_HEIGHT_MAX) ? MAP_HEIGHT_MAX : 32'(map_height_q);

  always_comb begin
    cfg.ready = map_loaded_q && (map_width_q != '0) && (map_height_q != '0);
    cfg.w_m1  = X_W'(w_eff - 32'd1);
    cfg.h_m1  = Y_W'(h_eff - 32'd1);
  end

  gbts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (in_data_t'(s_axis_tdata)),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  gbts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  gbts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .empty_i    (empty),
    .head_i     (head_item),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_status_o (m_axis_tuser)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the bilinear texture sampler: directed table then random phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbts_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_ITEMS   = 450;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LAT_BAND       = int'(DEG_55);
  localparam int HALF_TURN      = int'(DEG_180);
  localparam int FULL_TURN      = int'(DEG_360);

  // one result: channels in 8.8 and status
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    status_e           status;
  } pixel_t;

  // one line of the directed table: a register write or an input transaction
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic [1:0]  op;
    in_data_t    data;
    bit          pinned;
    pixel_t      px;
  } stim_row_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} ready_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tex_x, tex_y, red, green, blue, coord_u, coord_v, latitude, longitude
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // opcode
  logic [OP_W-1:0]      s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // out_red, out_green, out_blue
  logic [OUT_W-1:0]     m_axis_tdata;
  // status
  logic [STATUS_W-1:0]  m_axis_tuser;

  // predictor state
  bit [RGB_W-1:0]       texel_store [int unsigned];
  logic [CFG_WID_W-1:0] map_width_cfg  = MAP_WIDTH_RST;
  logic [CFG_HGT_W-1:0] map_height_cfg = MAP_HEIGHT_RST;
  logic                 map_loaded_cfg = 1'b0;

  stim_row_t stim_rows[$];
  pixel_t    expected_pixels[$];
  int     error_count      = 0;
  int     results_seen     = 0;
  int     cycle_count      = 0;
  int     burst_left       = 0;
  bit     bursty_sender    = 1'b1;
  int     holdoff_requests = 0;

  geo_bilinear_texture_sampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("ERROR result %0d, %s: got %0d, expected %0d", results_seen, what, got, want);
  endtask

  function automatic void add_row(input stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic int unsigned texel_key(input longint unsigned x, input longint unsigned y);
    return int'(y * MAP_WIDTH_MAX + x);
  endfunction

  function automatic bit map_ready();
    return map_loaded_cfg && map_width_cfg != 0 && map_height_cfg != 0;
  endfunction

  function automatic longint unsigned eff_width();
    return (map_width_cfg > MAP_WIDTH_MAX) ? MAP_WIDTH_MAX : map_width_cfg;
  endfunction

  function automatic longint unsigned eff_height();
    return (map_height_cfg > MAP_HEIGHT_MAX) ? MAP_HEIGHT_MAX : map_height_cfg;
  endfunction

  // four-neighbour blend with exact weights, one truncation to 8.8 at the end
  function automatic pixel_t blend_texels(input longint u, input longint v);
    longint unsigned w, h, uc, vc, px, py, x0, y0, x1, y1, tx, ty, top, bot, sum;
    bit [RGB_W-1:0] t00, t10, t01, t11;
    logic [CHAN_W-1:0] chan [3];
    int shift;
    w  = eff_width();
    h  = eff_height();
    uc = (u < 0) ? 0 : ((u > ONE_Q16) ? ONE_Q16 : u);
    vc = (v < 0) ? 0 : ((v > ONE_Q16) ? ONE_Q16 : v);
    px = uc * (w - 1);
    py = vc * (h - 1);
    x0 = px >> FRAC_W;
    y0 = py >> FRAC_W;
    tx = px & 64'hFFFF;
    ty = py & 64'hFFFF;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    t00 = texel_store[texel_key(x0, y0)];
    t10 = texel_store[texel_key(x1, y0)];
    t01 = texel_store[texel_key(x0, y1)];
    t11 = texel_store[texel_key(x1, y1)];
    for (int c = 0; c < 3; c++) begin
      shift = 16 - 8 * c;
      top = ((t00 >> shift) & 255) * (65536 - tx) + ((t10 >> shift) & 255) * tx;
      bot = ((t01 >> shift) & 255) * (65536 - tx) + ((t11 >> shift) & 255) * tx;
      sum = top * (65536 - ty) + bot * ty;
      chan[c] = CHAN_W'(sum >> 24);
    end
    return '{chan[0], chan[1], chan[2], ST_SAMPLED};
  endfunction

  // returns 1 when the transaction yields a result; texel writes update the store
  function automatic bit predict_pixel(input logic [1:0] op, input in_data_t d,
                                       output pixel_t px);
    longint lat, lon, span, u, v;
    px = '{FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_NOT_LOADED};
    case (op)
      OP_WRITE: begin
        texel_store[texel_key(d.tex_x, d.tex_y)] = {d.red, d.green, d.blue};
        px = '{16'd0, 16'd0, 16'd0, ST_WRITE_DONE};
        return 1'b1;
      end
      OP_SAMPLE_UV: begin
        if (map_ready()) px = blend_texels(d.coord_u, d.coord_v);
        return 1'b1;
      end
      OP_SAMPLE_GEO: begin
        lat = $signed(d.latitude);
        lon = $signed(d.longitude);
        if (!map_ready()) return 1'b1;
        if (lat > LAT_BAND || lat <= -LAT_BAND) begin
          px = '{GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL, ST_OUT_OF_BAND};
          return 1'b1;
        end
        // longitude wraps once into [0, 360) degrees
        span = lon + HALF_TURN;
        if (span >= FULL_TURN) span -= FULL_TURN;
        else if (span < 0) span += FULL_TURN;
        u = (span < 0) ? 0 : span / 360;
        v = (LAT_BAND - lat) / 110;
        px = blend_texels(u, v);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] op, input in_data_t d);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = '0;
    row.value   = '0;
    row.op      = op;
    row.data    = d;
    row.pinned  = 1'b0;
    row.px      = '{16'd0, 16'd0, 16'd0, ST_SAMPLED};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
    stim_row_t row;
    row         = item_row(OP_NONE, '0);
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.value   = value;
    return row;
  endfunction

  function automatic stim_row_t texel_row(input logic [TEX_X_W-1:0] x,
                                          input logic [TEX_Y_W-1:0] y,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    in_data_t d = '0;
    d.tex_x = x;
    d.tex_y = y;
    d.red   = r;
    d.green = g;
    d.blue  = b;
    return item_row(OP_WRITE, d);
  endfunction

  function automatic stim_row_t uv_row(input logic [COORD_W-1:0] u,
                                       input logic [COORD_W-1:0] v);
    in_data_t d = '0;
    d.coord_u = u;
    d.coord_v = v;
    return item_row(OP_SAMPLE_UV, d);
  endfunction

  function automatic stim_row_t geo_row(input logic [LAT_W-1:0] lat,
                                        input logic [LON_W-1:0] lon);
    in_data_t d = '0;
    d.latitude  = lat;
    d.longitude = lon;
    return item_row(OP_SAMPLE_GEO, d);
  endfunction

  function automatic stim_row_t pin(input stim_row_t row, input logic [CHAN_W-1:0] r,
                                    input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                                    input status_e st);
    row.pinned = 1'b1;
    row.px     = '{r, g, b, st};
    return row;
  endfunction

  // random request; writes mostly land inside the map in use
  function automatic void draw_request(input longint unsigned w, input longint unsigned h,
                                       output logic [1:0] op, output in_data_t d);
    int pick;
    d    = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      op = OP_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        d.tex_x = TEX_X_W'($urandom_range(0, int'(w) - 1));
        d.tex_y = TEX_Y_W'($urandom_range(0, int'(h) - 1));
      end
    end else if (pick < 55) begin
      op = OP_SAMPLE_UV;
      case ($urandom_range(0, 9))
        0: d.coord_u = '0;
        1: d.coord_u = COORD_W'(ONE_Q16);
        2: ;
        default: d.coord_u = COORD_W'($urandom_range(0, ONE_Q16));
      endcase
      case ($urandom_range(0, 9))
        0: d.coord_v = '0;
        1: d.coord_v = COORD_W'(ONE_Q16);
        2: ;
        default: d.coord_v = COORD_W'($urandom_range(0, ONE_Q16));
      endcase
    end else if (pick < 95) begin
      op = OP_SAMPLE_GEO;
      case ($urandom_range(0, 11))
        0: d.latitude = LAT_W'(LAT_BAND);
        1: d.latitude = LAT_W'(-LAT_BAND);
        2: d.latitude = LAT_W'(1 - LAT_BAND);
        3: ;
        4: d.latitude = LAT_W'(LAT_BAND + $urandom_range(1, 40 * 65536));
        5: d.latitude = LAT_W'(-LAT_BAND - $urandom_range(0, 40 * 65536));
        default: d.latitude = LAT_W'($urandom_range(0, 2 * LAT_BAND - 1) - (LAT_BAND - 1));
      endcase
      case ($urandom_range(0, 9))
        0: ;
        1: d.longitude = LON_W'(HALF_TURN);
        2: d.longitude = LON_W'(-HALF_TURN);
        default: d.longitude = LON_W'($urandom_range(0, 2 * HALF_TURN - 1) - HALF_TURN);
      endcase
    end else begin
      op = OP_NONE;
    end
  endfunction

  // sender: bursts of random length, random gaps in between
  task automatic send_item(input logic [1:0] op, input in_data_t d, input bit pinned,
                           input pixel_t pinned_px);
    int gap;
    bit has_result;
    pixel_t px;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (!bursty_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    has_result = predict_pixel(op, d, px);
    if (has_result) expected_pixels.insert(expected_pixels.size(), pinned ? pinned_px : px);
  endtask

  // stop sending and let every outstanding result come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    // opcode 3 items give no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write one register, then read it back
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAP_WIDTH: begin
        map_width_cfg = value[CFG_WID_W-1:0];
        want = 32'(value[CFG_WID_W-1:0]);
      end
      REG_MAP_HEIGHT: begin
        map_height_cfg = value[CFG_HGT_W-1:0];
        want = 32'(value[CFG_HGT_W-1:0]);
      end
      REG_MAP_LOADED: begin
        map_loaded_cfg = value[0];
        want = 32'(value[0]);
      end
      default: want = '0;
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch($sformatf("readback of register %0d", idx),
                                         prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: ready pattern changes mode now and then, plus requested long hold-offs
  initial begin
    ready_mode_e mode;
    int mode_left;
    int hold_left;
    int holds_taken;
    m_axis_tready = 1'b0;
    mode          = RX_ALWAYS;
    mode_left     = 0;
    hold_left     = 0;
    holds_taken   = 0;
    forever begin
      @(negedge clk_i);
      if (holds_taken != holdoff_requests) begin
        holds_taken = holdoff_requests;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_HALF:   m_axis_tready <= $urandom_range(0, 1);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (mode_left % 3) != 0;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing expected, status", 32'(m_axis_tuser), '1);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[15:0] !== want.red)
          report_mismatch("out_red", 32'(m_axis_tdata[15:0]), 32'(want.red));
        if (m_axis_tdata[31:16] !== want.green)
          report_mismatch("out_green", 32'(m_axis_tdata[31:16]), 32'(want.green));
        if (m_axis_tdata[47:32] !== want.blue)
          report_mismatch("out_blue", 32'(m_axis_tdata[47:32]), 32'(want.blue));
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t fill_row;
    logic [1:0] op;
    in_data_t d;
    pixel_t unused_px;
    int unsigned phase_w, phase_h, phase_len, phase;
    bit phase_loaded;
    int random_sent;
    longint unsigned w_eff, h_eff;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NONE;
    unused_px     = '{16'd0, 16'd0, 16'd0, ST_SAMPLED};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset the map is not loaded
    add_row(pin(uv_row(0, 0), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_NOT_LOADED));
    add_row(pin(geo_row(0, 0), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_NOT_LOADED));
    add_row(item_row(OP_NONE, '0));
    add_row(pin(texel_row(1023, 511, 0, 0, 0), 0, 0, 0, ST_WRITE_DONE));
    add_row(pin(texel_row(0, 0, 255, 255, 255), 0, 0, 0, ST_WRITE_DONE));
    // single texel map: every in-band sample is full scale
    add_row(cfg_row(REG_MAP_WIDTH, 1));
    add_row(cfg_row(REG_MAP_HEIGHT, 1));
    add_row(cfg_row(REG_MAP_LOADED, 1));
    add_row(pin(uv_row(0, 0), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_SAMPLED));
    add_row(pin(uv_row('1, '1), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_SAMPLED));
    add_row(pin(geo_row(LAT_BAND, 0), FULL_SCALE, FULL_SCALE, FULL_SCALE,
                ST_SAMPLED));
    add_row(pin(geo_row(LAT_BAND + 1, 0), GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL,
                ST_OUT_OF_BAND));
    add_row(pin(geo_row(-LAT_BAND, 0), GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL,
                ST_OUT_OF_BAND));
    add_row(pin(geo_row(25'h1000000, 26'h2000000), GRAY_LEVEL, GRAY_LEVEL,
                GRAY_LEVEL, ST_OUT_OF_BAND));
    add_row(pin(geo_row(25'h0FFFFFF, 26'h1FFFFFF), GRAY_LEVEL, GRAY_LEVEL,
                GRAY_LEVEL, ST_OUT_OF_BAND));
    // 2x2 map with distinct corners
    add_row(cfg_row(REG_MAP_WIDTH, 2));
    add_row(cfg_row(REG_MAP_HEIGHT, 2));
    add_row(pin(texel_row(1, 0, 0, 128, 255), 0, 0, 0, ST_WRITE_DONE));
    add_row(pin(texel_row(0, 1, 17, 34, 51), 0, 0, 0, ST_WRITE_DONE));
    add_row(pin(texel_row(1, 1, 200, 100, 50), 0, 0, 0, ST_WRITE_DONE));
    add_row(uv_row(32768, 32768));
    add_row(uv_row(65535, 1));
    add_row(uv_row(65536, 0));
    add_row(geo_row(1 - LAT_BAND, HALF_TURN - 1));
    add_row(geo_row(0, HALF_TURN));
    add_row(geo_row(0, 26'h2000000));
    add_row(geo_row(LAT_BAND, -HALF_TURN));
    // zero size or cleared loaded flag reads as not loaded
    add_row(cfg_row(REG_MAP_WIDTH, 0));
    add_row(pin(uv_row(100, 100), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_NOT_LOADED));
    add_row(cfg_row(REG_MAP_WIDTH, 2));
    add_row(cfg_row(REG_MAP_HEIGHT, 0));
    add_row(pin(geo_row(0, 0), FULL_SCALE, FULL_SCALE, FULL_SCALE, ST_NOT_LOADED));
    add_row(cfg_row(REG_MAP_HEIGHT, 2));
    add_row(cfg_row(REG_MAP_LOADED, 0));
    add_row(pin(uv_row(65536, 65536), FULL_SCALE, FULL_SCALE, FULL_SCALE,
                ST_NOT_LOADED));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        wait_drained();
        apb_write(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        send_item(stim_rows[i].op, stim_rows[i].data, stim_rows[i].pinned, stim_rows[i].px);
      end
    end

    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      phase_loaded = 1'b1;
      case (phase)
        0: begin phase_w = 1024; phase_h = 1;    end
        1: begin phase_w = 2047; phase_h = 1;    end
        2: begin phase_w = 1;    phase_h = 512;  end
        3: begin phase_w = 1;    phase_h = 1023; end
        default: begin
          phase_w = $urandom_range(1, 24);
          phase_h = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0: phase_loaded = 1'b0;
            1: phase_w = 0;
            2: phase_h = 0;
            default: ;
          endcase
        end
      endcase
      // junk above the register width must be dropped
      apb_write(REG_MAP_WIDTH, ($urandom << CFG_WID_W) | phase_w);
      apb_write(REG_MAP_HEIGHT, ($urandom << CFG_HGT_W) | phase_h);
      apb_write(REG_MAP_LOADED, ($urandom << 1) | phase_loaded);
      w_eff = (eff_width() == 0) ? 1 : eff_width();
      h_eff = (eff_height() == 0) ? 1 : eff_height();

      // every texel a sample can reach must hold data first
      if (map_ready()) begin
        for (longint unsigned y = 0; y < h_eff; y++) begin
          for (longint unsigned x = 0; x < w_eff; x++) begin
            if (!texel_store.exists(texel_key(x, y))) begin
              fill_row = texel_row(TEX_X_W'(x), TEX_Y_W'(y), 8'($urandom), 8'($urandom),
                                   8'($urandom));
              send_item(OP_WRITE, fill_row.data, 1'b0, unused_px);
            end
          end
        end
      end

      phase_len = (phase < 4) ? 15 : $urandom_range(20, 50);
      if (phase == 5) begin
        // long receiver hold-off while the sender keeps offering
        bursty_sender = 1'b0;
        holdoff_requests++;
        phase_len = 48;
      end
      repeat (phase_len) begin
        draw_request(w_eff, h_eff, op, d);
        send_item(op, d, 1'b0, unused_px);
        if (op != OP_NONE) random_sent++;
      end
      bursty_sender = 1'b1;
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_front.sv
hw/rtl/gbts_fifo.sv
hw/rtl/gbts_back.sv
hw/rtl/geo_bilinear_texture_sampler.sv
tb/sv/testbench.sv
